>>> src/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the symbol map of the base64url decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [16:0] NEED_MAX = 17'h1FFFF;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_DANGLING   = 2'd1,
        ST_OVER_CAP   = 2'd2,
        ST_BAD_SYMBOL = 2'd3
    } t_status;

    typedef struct packed {
        logic [5:0] value;
        logic       bad;
    } t_sym;

    typedef struct packed {
        logic [5:0] value;
        logic       bad;
        logic       has;
        logic       last;
    } t_item;

    function automatic t_sym sym_decode(input logic [7:0] c);
        t_sym r;
        r.value = 6'd0;
        r.bad   = 1'b0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.value = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2D) begin
            r.value = 6'd62;
        end else if (c == 8'h5F) begin
            r.value = 6'd63;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/base64url_decoder_top.sv
// ----------------------------------------------------------------------------
// base64url_decoder_top
// Streaming decoder for unpadded base64url text.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one character per
// transaction, with has_symbol and last_symbol flags. Output channel
// (o_out_valid / i_out_stall) carries decoded bytes and, after the last
// item of a string, one status transaction. A separate write channel
// (i_cfg_valid / o_cfg_ready, always ready) loads the capacity register.
// Each item passes through the queue, and its result is registered in
// the output register, which drains one result per cycle when not
// stalled and so sets the rate: one item per cycle, but an item that
// gives both a byte and the status stays at the queue head for its
// byte, then gives the status.
// A four-entry queue sits between the character mapper and the splice
// logic; o_in_stall rises only when that queue is full, so a stalled
// receiver backs up the queue before the sender sees a stall.
// Reset (synchronous, active low) empties the queue, clears the group
// state and sets capacity to its largest value.
// ----------------------------------------------------------------------------
`default_nettype none

module base64url_decoder_top #(
    parameter logic [31:0] MAX_CAPACITY = 32'd65535
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [15:0]    i_cfg_data,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire logic [7:0]     i_symbol,
    input  wire logic           i_has_symbol,
    input  wire logic           i_last_symbol,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic                o_kind,
    output logic [7:0]          o_data_byte,
    output logic [1:0]          o_status,
    output logic [15:0]         o_byte_count,
    output logic                o_last_result
);

    logic               w_q_full;
    logic               w_q_push;
    logic               w_q_pop;
    logic               w_q_nonempty;
    b64d_pkg::t_item    w_q_in;
    b64d_pkg::t_item    w_q_head;

    assign o_cfg_ready = 1'b1;

    b64d_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_symbol      (i_symbol),
        .i_has_symbol  (i_has_symbol),
        .i_last_symbol (i_last_symbol),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_q_item      (w_q_in)
    );

    b64d_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_q_push),
        .i_item     (w_q_in),
        .i_pop      (w_q_pop),
        .o_full     (w_q_full),
        .o_nonempty (w_q_nonempty),
        .o_head     (w_q_head)
    );

    b64d_back #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_q_nonempty  (w_q_nonempty),
        .i_q_head      (w_q_head),
        .o_q_pop       (w_q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_data_byte   (o_data_byte),
        .o_status      (o_status),
        .o_byte_count  (o_byte_count),
        .o_last_result (o_last_result)
    );

endmodule

`default_nettype wire

>>> src/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts input transactions, maps the character and drops empty items.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front (
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic [7:0]      i_symbol,
    input  wire logic            i_has_symbol,
    input  wire logic            i_last_symbol,
    input  wire logic            i_q_full,
    output logic                 o_q_push,
    output b64d_pkg::t_item      o_q_item
);

    b64d_pkg::t_sym w_sym;

    always_comb begin
        w_sym            = b64d_pkg::sym_decode(i_symbol);
        o_in_stall       = i_q_full;
        o_q_push         = i_in_valid && !i_q_full && (i_has_symbol || i_last_symbol);
        o_q_item.value   = w_sym.bad ? 6'd0 : w_sym.value;
        o_q_item.bad     = i_has_symbol && w_sym.bad;
        o_q_item.has     = i_has_symbol;
        o_q_item.last    = i_last_symbol;
    end

endmodule

`default_nettype wire

>>> src/b64d_fifo.sv
// ----------------------------------------------------------------------------
// b64d_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  b64d_pkg::t_item      i_item,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_nonempty,
    output b64d_pkg::t_item      o_head
);

    b64d_pkg::t_item                     r_mem [b64d_pkg::FIFO_DEPTH];
    logic [b64d_pkg::FIFO_PTR_W-1:0]     r_wr_ptr;
    logic [b64d_pkg::FIFO_PTR_W-1:0]     r_rd_ptr;
    logic [b64d_pkg::FIFO_CNT_W-1:0]     r_count;
    logic [b64d_pkg::FIFO_CNT_W-1:0]     n_count;
    logic                                w_pop;

    always_comb begin
        o_full     = (r_count == b64d_pkg::FIFO_CNT_W'(b64d_pkg::FIFO_DEPTH));
        o_nonempty = (r_count != '0);
        o_head     = r_mem[r_rd_ptr];
        w_pop      = i_pop && o_nonempty;
        n_count    = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> src/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Splices symbols into bytes, tracks length and errors, drives the output.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back #(
    parameter logic [31:0] MAX_CAPACITY = 32'd65535
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    input  wire logic [15:0]     i_cfg_data,
    input  wire logic            i_q_nonempty,
    input  b64d_pkg::t_item      i_q_head,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic                 o_kind,
    output logic [7:0]           o_data_byte,
    output logic [1:0]           o_status,
    output logic [15:0]          o_byte_count,
    output logic                 o_last_result
);

    localparam logic [15:0] LimCeil =
        (MAX_CAPACITY > 32'd65535) ? 16'hFFFF : MAX_CAPACITY[15:0];

    logic [15:0]    r_limit;
    logic [1:0]     r_phase,  n_phase;
    logic [5:0]     r_carry,  n_carry;
    logic [16:0]    r_need,   n_need;
    logic           r_bad,    n_bad;
    logic           r_sub,    n_sub;

    logic           r_out_valid;
    logic           r_kind;
    logic [7:0]     r_byte;
    logic [1:0]     r_status;
    logic [15:0]    r_count;
    logic           r_last;

    logic           w_out_ready;
    logic           w_step;
    logic           w_has;
    logic           w_makes;
    logic           w_emit_byte;
    logic [7:0]     w_byte;
    logic [1:0]     w_status;
    logic [15:0]    w_count;

    always_comb begin
        w_out_ready = !r_out_valid || !i_out_stall;
        w_step      = w_out_ready && i_q_nonempty;
        w_has       = i_q_head.has && !r_sub;

        n_phase = r_phase;
        n_carry = r_carry;
        n_need  = r_need;
        n_bad   = r_bad;
        n_sub   = r_sub;
        w_makes = 1'b0;
        w_byte  = 8'd0;

        if (w_has) begin
            n_bad   = r_bad || i_q_head.bad;
            n_phase = r_phase + 1'b1;
            case (r_phase)
                2'd0: begin
                    n_carry = i_q_head.value;
                end
                2'd1: begin
                    w_byte  = {r_carry, i_q_head.value[5:4]};
                    n_carry = {2'b00, i_q_head.value[3:0]};
                    w_makes = 1'b1;
                end
                2'd2: begin
                    w_byte  = {r_carry[3:0], i_q_head.value[5:2]};
                    n_carry = {4'b0000, i_q_head.value[1:0]};
                    w_makes = 1'b1;
                end
                default: begin
                    w_byte  = {r_carry[1:0], i_q_head.value};
                    n_carry = 6'd0;
                    w_makes = 1'b1;
                end
            endcase
            if (w_makes && r_need != b64d_pkg::NEED_MAX) begin
                n_need = r_need + 1'b1;
            end
        end

        w_emit_byte = w_makes && !n_bad && (n_need <= {1'b0, r_limit});

        if (n_phase == 2'd1) begin
            w_status = b64d_pkg::ST_DANGLING;
        end else if (n_need > {1'b0, r_limit}) begin
            w_status = b64d_pkg::ST_OVER_CAP;
        end else if (n_bad) begin
            w_status = b64d_pkg::ST_BAD_SYMBOL;
        end else begin
            w_status = b64d_pkg::ST_OK;
        end
        w_count = (w_status == b64d_pkg::ST_OK) ? n_need[15:0] : 16'd0;

        o_q_pop = w_step && !(w_emit_byte && i_q_head.last);
        if (w_emit_byte && i_q_head.last) begin
            n_sub = 1'b1;
        end else if (i_q_head.last) begin
            n_sub   = 1'b0;
            n_phase = 2'd0;
            n_carry = 6'd0;
            n_need  = '0;
            n_bad   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimCeil;
        end else if (i_cfg_valid) begin
            r_limit <= (i_cfg_data > LimCeil) ? LimCeil : i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 2'd0;
            r_carry     <= 6'd0;
            r_need      <= '0;
            r_bad       <= 1'b0;
            r_sub       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_phase <= n_phase;
                r_carry <= n_carry;
                r_need  <= n_need;
                r_bad   <= n_bad;
                r_sub   <= n_sub;
            end
            if (w_out_ready) begin
                r_out_valid <= w_step && (w_emit_byte || i_q_head.last);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            if (w_emit_byte) begin
                r_kind   <= b64d_pkg::KIND_DATA;
                r_byte   <= w_byte;
                r_status <= b64d_pkg::ST_OK;
                r_count  <= 16'd0;
                r_last   <= !i_q_head.last;
            end else begin
                r_kind   <= b64d_pkg::KIND_STATUS;
                r_byte   <= 8'd0;
                r_status <= w_status;
                r_count  <= w_count;
                r_last   <= 1'b1;
            end
        end
    end

    always_comb begin
        o_out_valid   = r_out_valid;
        o_kind        = r_kind;
        o_data_byte   = r_byte;
        o_status      = r_status;
        o_byte_count  = r_count;
        o_last_result = r_last;
    end

`ifndef SYNTHESIS
    a_sub_holds_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> r_out_valid)
        else $error("pending status without a byte in the output register");

    a_err_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == b64d_pkg::KIND_STATUS && r_status != b64d_pkg::ST_OK)
            |-> r_count == 16'd0)
        else $error("nonzero byte count on error status");

    a_data_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == b64d_pkg::KIND_DATA) |-> r_status == b64d_pkg::ST_OK)
        else $error("data transaction carries a status");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_head.last) |=> (r_phase == 2'd0 && r_need == '0 && !r_bad))
        else $error("string state not cleared after last item");
`endif

endmodule

`default_nettype wire

>>> bench/base64url_decoder_top_test.sv
// ----------------------------------------------------------------------------
// base64url_decoder_top_test
// Self-checking bench for the streaming base64url decoder.
// ----------------------------------------------------------------------------
// Drives characters through the valid/stall input channel and loads the
// capacity register between strings. A scoreboard tracks the group
// position, leftover bits, byte count and bad-character flag of the
// current string, predicts every decoded byte and status transaction,
// and checks each output transaction field by field in order. Stimulus
// covers hand-picked strings (empty, dangling symbol, bad characters,
// error priority), then random strings over several capacities with
// random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module base64url_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BUFFER_MAX    = 65535;
    localparam int          RANDOM_ITEMS  = 850;
    localparam int          DRAIN_LIMIT   = 5000;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          CAP_PHASES    = 7;

    typedef struct packed {
        logic              kind;
        logic [7:0]        data_byte;
        b64d_pkg::t_status status;
        logic [15:0]       byte_count;
        logic              last_result;
    } decode_result_t;

    class decode_scoreboard;
        decode_result_t expected_q[$];
        logic [15:0]    capacity;
        logic [1:0]     group_phase;
        logic [5:0]     carry_bits;
        logic [16:0]    need_count;
        logic           bad_seen;
        int unsigned    errors;

        function new();
            capacity = 16'hFFFF;
            errors   = 0;
            clear_string();
        endfunction

        function void clear_string();
            group_phase = 2'd0;
            carry_bits  = 6'd0;
            need_count  = 17'd0;
            bad_seen    = 1'b0;
        endfunction

        function void set_capacity(logic [15:0] value);
            capacity = value;
        endfunction

        function logic [16:0] byte_limit();
            return (capacity < BUFFER_MAX) ? 17'(capacity) : 17'(BUFFER_MAX);
        endfunction

        function void note_item(logic [7:0] sym, logic has, logic last);
            decode_result_t    made[$];
            decode_result_t    r;
            logic [5:0]        v;
            logic              sym_bad;
            logic [7:0]        value_byte;
            logic              makes;
            b64d_pkg::t_status st;
            v          = 6'd0;
            sym_bad    = 1'b0;
            value_byte = 8'd0;
            makes      = 1'b1;
            if (has) begin
                if (sym >= "A" && sym <= "Z") begin
                    v = 6'(sym - "A");
                end else if (sym >= "a" && sym <= "z") begin
                    v = 6'(sym - "a" + 8'd26);
                end else if (sym >= "0" && sym <= "9") begin
                    v = 6'(sym - "0" + 8'd52);
                end else if (sym == "-") begin
                    v = 6'd62;
                end else if (sym == "_") begin
                    v = 6'd63;
                end else begin
                    sym_bad = 1'b1;
                end
                if (sym_bad) begin
                    bad_seen = 1'b1;
                end
                case (group_phase)
                    2'd0: begin
                        carry_bits = v;
                        makes      = 1'b0;
                    end
                    2'd1: begin
                        value_byte = {carry_bits, v[5:4]};
                        carry_bits = {2'b00, v[3:0]};
                    end
                    2'd2: begin
                        value_byte = {carry_bits[3:0], v[5:2]};
                        carry_bits = {4'b0000, v[1:0]};
                    end
                    default: begin
                        value_byte = {carry_bits[1:0], v};
                        carry_bits = 6'd0;
                    end
                endcase
                group_phase = group_phase + 2'd1;
                if (makes) begin
                    if (need_count != b64d_pkg::NEED_MAX) begin
                        need_count = need_count + 17'd1;
                    end
                    if (!bad_seen && need_count <= byte_limit()) begin
                        r = '{b64d_pkg::KIND_DATA, value_byte, b64d_pkg::ST_OK,
                              16'd0, 1'b0};
                        made.push_back(r);
                    end
                end
            end
            if (last) begin
                if (group_phase == 2'd1) begin
                    st = b64d_pkg::ST_DANGLING;
                end else if (need_count > byte_limit()) begin
                    st = b64d_pkg::ST_OVER_CAP;
                end else if (bad_seen) begin
                    st = b64d_pkg::ST_BAD_SYMBOL;
                end else begin
                    st = b64d_pkg::ST_OK;
                end
                r = '{b64d_pkg::KIND_STATUS, 8'd0, st,
                      (st == b64d_pkg::ST_OK) ? need_count[15:0] : 16'd0, 1'b0};
                made.push_back(r);
                clear_string();
            end
            if (made.size() > 0) begin
                made[made.size() - 1].last_result = 1'b1;
            end
            foreach (made[i]) begin
                expected_q.push_back(made[i]);
            end
        endfunction

        function void field_check(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(decode_result_t got);
            decode_result_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected transaction: kind %0d byte %0d status %0d count %0d",
                       got.kind, got.data_byte, got.status, got.byte_count);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            field_check("kind", want.kind, got.kind);
            field_check("data_byte", want.data_byte, got.data_byte);
            field_check("status", int'(want.status), int'(got.status));
            field_check("byte_count", want.byte_count, got.byte_count);
            field_check("last_result", want.last_result, got.last_result);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void final_check();
            if (expected_q.size() > 0) begin
                $error("%0d expected transactions never arrived", expected_q.size());
                errors += expected_q.size();
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [15:0] i_cfg_data    = 16'd0;
    logic        i_in_valid    = 1'b0;
    logic [7:0]  i_symbol      = 8'd0;
    logic        i_has_symbol  = 1'b0;
    logic        i_last_symbol = 1'b0;
    logic        i_out_stall   = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_kind;
    logic [7:0]  o_data_byte;
    logic [1:0]  o_status;
    logic [15:0] o_byte_count;
    logic        o_last_result;

    decode_scoreboard sb = new();
    bit               idling_on    = 1'b0;
    int unsigned      hold_request = 0;

    base64url_decoder_top #(
        .MAX_CAPACITY (32'(BUFFER_MAX))
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_symbol      (i_symbol),
        .i_has_symbol  (i_has_symbol),
        .i_last_symbol (i_last_symbol),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_data_byte   (o_data_byte),
        .o_status      (o_status),
        .o_byte_count  (o_byte_count),
        .o_last_result (o_last_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(decode_result_t'{o_kind, o_data_byte,
                                             b64d_pkg::t_status'(o_status),
                                             o_byte_count, o_last_result});
        end
    end

    initial begin : receiver
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] alphabet_char(int unsigned idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        if (idx == 62) return "-";
        return "_";
    endfunction

    task automatic send_item(input logic [7:0] sym, input logic has, input logic last);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_symbol      <= sym;
        i_has_symbol  <= has;
        i_last_symbol <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(sym, has, last);
        @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_capacity(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        int cycles;
        cycles = 0;
        i_in_valid <= 1'b0;
        while (sb.pending() != 0 && cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random_string(inout int produced);
        int   len;
        bit   end_apart;
        logic [7:0] sym;
        len       = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(0, 12);
        end_apart = $urandom_range(0, 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            sym = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                               : alphabet_char($urandom_range(0, 63));
            send_item(sym, 1'b1, !end_apart && i == len - 1);
            produced++;
        end
        if (end_apart || len == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            produced++;
        end
    endtask

    initial begin : stimulus
        int          produced;
        logic [15:0] caps [CAP_PHASES];
        produced = 0;
        caps     = '{16'd0, 16'd1, 16'd2, 16'd3, 16'($urandom_range(4, 24)),
                     16'($urandom_range(0, 65535)), 16'hFFFF};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(8'h00, 1'b0, 1'b1);
        send_item("_", 1'b1, 1'b0);
        send_item("-", 1'b1, 1'b0);
        send_item("A", 1'b1, 1'b0);
        send_item("z", 1'b1, 1'b1);
        send_item("0", 1'b1, 1'b0);
        send_item("9", 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item("a", 1'b1, 1'b0);
        send_item("Z", 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item("R", 1'b1, 1'b1);
        send_item("Q", 1'b1, 1'b0);
        send_item("Q", 1'b1, 1'b1);
        send_item("T", 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item("W", 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item("@", 1'b1, 1'b0);
        send_item("A", 1'b1, 1'b0);
        send_item("A", 1'b1, 1'b0);
        send_item("A", 1'b1, 1'b0);
        send_item("B", 1'b1, 1'b1);
        wait_quiet();

        write_capacity(16'd1);
        send_item("Q", 1'b1, 1'b0);
        send_item("U", 1'b1, 1'b0);
        send_item("J", 1'b1, 1'b0);
        send_item("=", 1'b1, 1'b1);
        send_item("Q", 1'b1, 1'b0);
        send_item("U", 1'b1, 1'b0);
        send_item("J", 1'b1, 1'b0);
        send_item("D", 1'b1, 1'b0);
        send_item("Q", 1'b1, 1'b1);
        wait_quiet();

        idling_on = 1'b1;
        for (int p = 0; p < CAP_PHASES; p++) begin
            write_capacity(caps[p]);
            if (p == 2) begin
                hold_request = 80;
            end
            if (p == CAP_PHASES - 1) begin
                idling_on = 1'b0;
            end
            while (produced < RANDOM_ITEMS * (p + 1) / CAP_PHASES) begin
                send_random_string(produced);
            end
            wait_quiet();
        end

        sb.final_check();
        if (sb.errors == 0) begin
            $display("** base64url_decoder_top: PASSED **");
        end else begin
            $display("** base64url_decoder_top: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #15_000_000;
        $display("** base64url_decoder_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
